@@ rtl/ilsm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ilsm_pkg: shared types and constants of the indexed list store
// Widths, operation and status codes, the queued command and the state
// encoding of the execution sequencer.
// ----------------------------------------------------------------------------
package ilsm_pkg;

    localparam int LIST_DEPTH  = 16;
    localparam int IDX_W       = $clog2(LIST_DEPTH);
    localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
    localparam int TOT_W       = CNT_W + 1;
    localparam int POS_W       = 5;
    localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int DATA_W      = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_MERGE  = 2'd2;

    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_EMPTY = 2'd3;

    typedef enum logic [1:0] {
        KIND_INS,
        KIND_DEL,
        KIND_MERGE,
        KIND_RESP
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic               sel;
        logic [IDX_W-1:0]   pos;
        logic [CNT_W-1:0]   cnt_a;
        logic [CNT_W-1:0]   cnt_b;
        logic [DATA_W-1:0]  value;
        logic [1:0]         status;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_SHIFT,
        ST_INS_PUT,
        ST_DEL_GRAB,
        ST_DEL_SHIFT,
        ST_DEL_DONE,
        ST_MERGE,
        ST_RESP
    } t_back_state;

endpackage
`default_nettype wire

@@ rtl/indexed_list_store_with_sorted_merge.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_list_store_with_sorted_merge: two indexed lists with sorted merge
// Insert and delete at an index in either of two lists of signed words,
// and a streamed two-way merge of both lists.
// ----------------------------------------------------------------------------
// The intake takes one transaction per clock while its four-entry command
// queue has room; it checks the index against the list lengths at once, so
// refused transactions cost no list work. Execution is bound by the single
// read and write port of each list memory and moves one entry per cycle:
// an insert at position p into a list of n entries shifts the n - p entries
// from p upward, a delete shifts the entries above p down, a merge streams
// its results in order (up to 2 * LIST_DEPTH results), and a refused insert
// or delete or an empty merge only returns its status. Each result is held in
// an output register, so a stalled result only stops the executor when it
// has its next result ready. List contents are undefined after reset; only
// entries below the current length are ever read.
module indexed_list_store_with_sorted_merge (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output      logic                         o_in_stall,
    input  wire logic [1:0]                   i_operation,
    input  wire logic                         i_list_select,
    input  wire logic [ilsm_pkg::POS_W-1:0]   i_position,
    input  wire logic signed [ilsm_pkg::DATA_W-1:0] i_item_value,
    output      logic                         o_out_valid,
    input  wire logic                         i_out_stall,
    output      logic signed [ilsm_pkg::DATA_W-1:0] o_result_value,
    output      logic [1:0]                   o_status,
    output      logic                         o_last_result
);

    logic           w_push;
    ilsm_pkg::t_cmd w_cmd;
    logic           w_full;
    logic           w_pop;
    logic           w_head_valid;
    ilsm_pkg::t_cmd w_head;

    ilsm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_list_select (i_list_select),
        .i_position    (i_position),
        .i_item_value  (i_item_value),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_cmd         (w_cmd)
    );

    ilsm_cmd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_cmd        (w_cmd),
        .o_full       (w_full),
        .i_pop        (w_pop),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    ilsm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head_valid   (w_head_valid),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_value (o_result_value),
        .o_status       (o_status),
        .o_last_result  (o_last_result)
    );

endmodule
`default_nettype wire

@@ rtl/ilsm_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ilsm_front: transaction intake and classification
// Tracks both list lengths, checks the index, and queues a command that
// already carries its final status and the lengths it needs.
// ----------------------------------------------------------------------------
module ilsm_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output      logic                         o_in_stall,
    input  wire logic [1:0]                   i_operation,
    input  wire logic                         i_list_select,
    input  wire logic [ilsm_pkg::POS_W-1:0]   i_position,
    input  wire logic signed [ilsm_pkg::DATA_W-1:0] i_item_value,
    input  wire logic                         i_full,
    output      logic                         o_push,
    output      ilsm_pkg::t_cmd               o_cmd
);

    logic [ilsm_pkg::CNT_W-1:0] r_cnt_a, n_cnt_a;
    logic [ilsm_pkg::CNT_W-1:0] r_cnt_b, n_cnt_b;
    logic [ilsm_pkg::CNT_W-1:0] w_cnt;
    logic [ilsm_pkg::CMP_W-1:0] w_pos_x;
    logic [ilsm_pkg::CMP_W-1:0] w_cnt_x;
    logic                       w_accept;

    assign o_in_stall = i_full;
    assign w_accept   = i_in_valid && !i_full;
    assign w_cnt      = i_list_select ? r_cnt_b : r_cnt_a;
    assign w_pos_x    = ilsm_pkg::CMP_W'(i_position);
    assign w_cnt_x    = ilsm_pkg::CMP_W'(w_cnt);

    always_comb begin
        n_cnt_a      = r_cnt_a;
        n_cnt_b      = r_cnt_b;
        o_push       = 1'b0;
        o_cmd.kind   = ilsm_pkg::KIND_RESP;
        o_cmd.sel    = i_list_select;
        o_cmd.pos    = ilsm_pkg::IDX_W'(i_position);
        o_cmd.cnt_a  = r_cnt_a;
        o_cmd.cnt_b  = r_cnt_b;
        o_cmd.value  = i_item_value;
        o_cmd.status = ilsm_pkg::STAT_DONE;
        unique case (i_operation)
            ilsm_pkg::OP_INSERT: begin
                o_push = w_accept;
                if (w_pos_x > w_cnt_x) begin
                    o_cmd.status = ilsm_pkg::STAT_RANGE;
                end else if (w_cnt == ilsm_pkg::CNT_W'(ilsm_pkg::LIST_DEPTH)) begin
                    o_cmd.status = ilsm_pkg::STAT_FULL;
                end else begin
                    o_cmd.kind = ilsm_pkg::KIND_INS;
                    if (w_accept) begin
                        if (i_list_select) begin
                            n_cnt_b = r_cnt_b + ilsm_pkg::CNT_W'(1);
                        end else begin
                            n_cnt_a = r_cnt_a + ilsm_pkg::CNT_W'(1);
                        end
                    end
                end
            end
            ilsm_pkg::OP_DELETE: begin
                o_push = w_accept;
                if (w_pos_x >= w_cnt_x) begin
                    o_cmd.status = ilsm_pkg::STAT_RANGE;
                end else begin
                    o_cmd.kind = ilsm_pkg::KIND_DEL;
                    if (w_accept) begin
                        if (i_list_select) begin
                            n_cnt_b = r_cnt_b - ilsm_pkg::CNT_W'(1);
                        end else begin
                            n_cnt_a = r_cnt_a - ilsm_pkg::CNT_W'(1);
                        end
                    end
                end
            end
            ilsm_pkg::OP_MERGE: begin
                o_push = w_accept;
                if (r_cnt_a == '0 && r_cnt_b == '0) begin
                    o_cmd.status = ilsm_pkg::STAT_EMPTY;
                end else begin
                    o_cmd.kind = ilsm_pkg::KIND_MERGE;
                end
            end
            default: begin
                // drop the unused operation code
                o_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a <= '0;
            r_cnt_b <= '0;
        end else begin
            r_cnt_a <= n_cnt_a;
            r_cnt_b <= n_cnt_b;
        end
    end

endmodule
`default_nettype wire

@@ rtl/ilsm_cmd_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ilsm_cmd_queue: command queue between intake and execution
// A small first-in first-out buffer of classified commands.
// ----------------------------------------------------------------------------
module ilsm_cmd_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire ilsm_pkg::t_cmd i_cmd,
    output      logic           o_full,
    input  wire logic           i_pop,
    output      logic           o_head_valid,
    output      ilsm_pkg::t_cmd o_head
);

    ilsm_pkg::t_cmd              r_ent [ilsm_pkg::QUEUE_DEPTH];
    logic [ilsm_pkg::QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [ilsm_pkg::QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [ilsm_pkg::QCNT_W-1:0] r_fill, n_fill;
    logic                        w_do_push;
    logic                        w_do_pop;

    assign o_full       = (r_fill == ilsm_pkg::QCNT_W'(ilsm_pkg::QUEUE_DEPTH));
    assign o_head_valid = (r_fill != '0);
    assign o_head       = r_ent[r_rd_ptr];
    assign w_do_push    = i_push && !o_full;
    assign w_do_pop     = i_pop && o_head_valid;

    always_comb begin
        n_wr_ptr = w_do_push ? ilsm_pkg::QPTR_W'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = w_do_pop  ? ilsm_pkg::QPTR_W'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_fill   = r_fill;
        if (w_do_push && !w_do_pop) begin
            n_fill = r_fill + ilsm_pkg::QCNT_W'(1);
        end else if (w_do_pop && !w_do_push) begin
            n_fill = r_fill - ilsm_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_ent[r_wr_ptr] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

@@ rtl/ilsm_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ilsm_back: command execution and result register
// Holds both list memories, walks the shifts of insert and delete one
// entry a cycle and streams the sorted merge into the output register.
// ----------------------------------------------------------------------------
module ilsm_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_head_valid,
    input  wire ilsm_pkg::t_cmd i_head,
    output      logic           o_pop,
    output      logic           o_out_valid,
    input  wire logic           i_out_stall,
    output      logic signed [ilsm_pkg::DATA_W-1:0] o_result_value,
    output      logic [1:0]     o_status,
    output      logic           o_last_result
);

    logic [ilsm_pkg::DATA_W-1:0] r_mem_a [ilsm_pkg::LIST_DEPTH];
    logic [ilsm_pkg::DATA_W-1:0] r_mem_b [ilsm_pkg::LIST_DEPTH];
    logic [ilsm_pkg::DATA_W-1:0] r_qa;
    logic [ilsm_pkg::DATA_W-1:0] r_qb;

    ilsm_pkg::t_back_state       r_state, n_state;
    logic [ilsm_pkg::CNT_W-1:0]  r_ia, n_ia;
    logic [ilsm_pkg::CNT_W-1:0]  r_ib, n_ib;
    logic                        r_sel;
    logic [ilsm_pkg::IDX_W-1:0]  r_pos;
    logic [ilsm_pkg::CNT_W-1:0]  r_cnt;
    logic [ilsm_pkg::CNT_W-1:0]  r_n1;
    logic [ilsm_pkg::CNT_W-1:0]  r_n2;
    logic [ilsm_pkg::DATA_W-1:0] r_val;
    logic [1:0]                  r_stat;
    logic [ilsm_pkg::DATA_W-1:0] r_rem, n_rem;

    logic                        r_out_valid;
    logic [ilsm_pkg::DATA_W-1:0] r_out_value;
    logic [1:0]                  r_out_status;
    logic                        r_out_last;

    logic                        w_out_free;
    logic [ilsm_pkg::CNT_W-1:0]  w_ix;
    logic [ilsm_pkg::DATA_W-1:0] w_q;
    logic                        w_ix_at_pos;
    logic                        w_ix_at_end;
    logic [ilsm_pkg::CNT_W-1:0]  w_head_cnt;
    logic                        w_take_a;
    logic                        w_merge_last;

    logic                        w_we;
    logic [ilsm_pkg::IDX_W-1:0]  w_wr_addr;
    logic [ilsm_pkg::DATA_W-1:0] w_wr_data;
    logic                        w_emit;
    logic [ilsm_pkg::DATA_W-1:0] w_emit_value;
    logic [1:0]                  w_emit_status;
    logic                        w_emit_last;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_ix        = r_sel ? r_ib : r_ia;
    assign w_q         = r_sel ? r_qb : r_qa;
    assign w_ix_at_pos = (w_ix == ilsm_pkg::CNT_W'(r_pos));
    assign w_ix_at_end = (w_ix == r_cnt - ilsm_pkg::CNT_W'(1));
    assign w_head_cnt  = i_head.sel ? i_head.cnt_b : i_head.cnt_a;

    // ties go to the second list
    assign w_take_a = (r_ia < r_n1)
                   && ((r_ib >= r_n2) || ($signed(r_qa) < $signed(r_qb)));
    assign w_merge_last = (ilsm_pkg::TOT_W'(r_ia) + ilsm_pkg::TOT_W'(r_ib)
                           + ilsm_pkg::TOT_W'(1))
                       == (ilsm_pkg::TOT_W'(r_n1) + ilsm_pkg::TOT_W'(r_n2));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ilsm_pkg::ST_IDLE: begin
                if (i_head_valid) begin
                    unique case (i_head.kind)
                        ilsm_pkg::KIND_INS: begin
                            n_state = (w_head_cnt == ilsm_pkg::CNT_W'(i_head.pos))
                                    ? ilsm_pkg::ST_INS_PUT : ilsm_pkg::ST_INS_SHIFT;
                        end
                        ilsm_pkg::KIND_DEL:   n_state = ilsm_pkg::ST_DEL_GRAB;
                        ilsm_pkg::KIND_MERGE: n_state = ilsm_pkg::ST_MERGE;
                        ilsm_pkg::KIND_RESP:  n_state = ilsm_pkg::ST_RESP;
                        default:              n_state = ilsm_pkg::ST_IDLE;
                    endcase
                end
            end
            ilsm_pkg::ST_INS_SHIFT: begin
                if (w_ix_at_pos) begin
                    n_state = ilsm_pkg::ST_INS_PUT;
                end
            end
            ilsm_pkg::ST_DEL_GRAB, ilsm_pkg::ST_DEL_SHIFT: begin
                if (w_ix_at_end) begin
                    n_state = ilsm_pkg::ST_DEL_DONE;
                end else begin
                    n_state = ilsm_pkg::ST_DEL_SHIFT;
                end
            end
            ilsm_pkg::ST_INS_PUT, ilsm_pkg::ST_DEL_DONE, ilsm_pkg::ST_RESP: begin
                if (w_out_free) begin
                    n_state = ilsm_pkg::ST_IDLE;
                end
            end
            ilsm_pkg::ST_MERGE: begin
                if (w_out_free && w_merge_last) begin
                    n_state = ilsm_pkg::ST_IDLE;
                end
            end
            default: n_state = ilsm_pkg::ST_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        n_ia          = r_ia;
        n_ib          = r_ib;
        n_rem         = r_rem;
        o_pop         = 1'b0;
        w_we          = 1'b0;
        w_wr_addr     = r_pos;
        w_wr_data     = r_val;
        w_emit        = 1'b0;
        w_emit_value  = '0;
        w_emit_status = ilsm_pkg::STAT_DONE;
        w_emit_last   = 1'b1;
        unique case (r_state)
            ilsm_pkg::ST_IDLE: begin
                if (i_head_valid) begin
                    o_pop = 1'b1;
                    unique case (i_head.kind)
                        ilsm_pkg::KIND_INS: begin
                            // start the upward shift at the last entry
                            if (i_head.sel) begin
                                n_ib = w_head_cnt - ilsm_pkg::CNT_W'(1);
                            end else begin
                                n_ia = w_head_cnt - ilsm_pkg::CNT_W'(1);
                            end
                        end
                        ilsm_pkg::KIND_DEL: begin
                            if (i_head.sel) begin
                                n_ib = ilsm_pkg::CNT_W'(i_head.pos);
                            end else begin
                                n_ia = ilsm_pkg::CNT_W'(i_head.pos);
                            end
                        end
                        ilsm_pkg::KIND_MERGE: begin
                            n_ia = '0;
                            n_ib = '0;
                        end
                        default: begin
                            n_ia = r_ia;
                        end
                    endcase
                end
            end
            ilsm_pkg::ST_INS_SHIFT: begin
                w_we      = 1'b1;
                w_wr_addr = ilsm_pkg::IDX_W'(w_ix + ilsm_pkg::CNT_W'(1));
                w_wr_data = w_q;
                if (!w_ix_at_pos) begin
                    if (r_sel) begin
                        n_ib = r_ib - ilsm_pkg::CNT_W'(1);
                    end else begin
                        n_ia = r_ia - ilsm_pkg::CNT_W'(1);
                    end
                end
            end
            ilsm_pkg::ST_INS_PUT: begin
                if (w_out_free) begin
                    w_we   = 1'b1;
                    w_emit = 1'b1;
                end
            end
            ilsm_pkg::ST_DEL_GRAB, ilsm_pkg::ST_DEL_SHIFT: begin
                if (r_state == ilsm_pkg::ST_DEL_GRAB) begin
                    n_rem = w_q;
                end else begin
                    w_we      = 1'b1;
                    w_wr_addr = ilsm_pkg::IDX_W'(w_ix - ilsm_pkg::CNT_W'(1));
                    w_wr_data = w_q;
                end
                if (!w_ix_at_end) begin
                    if (r_sel) begin
                        n_ib = r_ib + ilsm_pkg::CNT_W'(1);
                    end else begin
                        n_ia = r_ia + ilsm_pkg::CNT_W'(1);
                    end
                end
            end
            ilsm_pkg::ST_DEL_DONE: begin
                w_emit       = w_out_free;
                w_emit_value = r_rem;
            end
            ilsm_pkg::ST_RESP: begin
                w_emit        = w_out_free;
                w_emit_status = r_stat;
            end
            ilsm_pkg::ST_MERGE: begin
                if (w_out_free) begin
                    w_emit       = 1'b1;
                    w_emit_last  = w_merge_last;
                    w_emit_value = w_take_a ? r_qa : r_qb;
                    if (w_take_a) begin
                        n_ia = r_ia + ilsm_pkg::CNT_W'(1);
                    end else begin
                        n_ib = r_ib + ilsm_pkg::CNT_W'(1);
                    end
                end
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ilsm_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ia  <= n_ia;
        r_ib  <= n_ib;
        r_rem <= n_rem;
        if (o_pop) begin
            r_sel  <= i_head.sel;
            r_pos  <= i_head.pos;
            r_cnt  <= w_head_cnt;
            r_n1   <= i_head.cnt_a;
            r_n2   <= i_head.cnt_b;
            r_val  <= i_head.value;
            r_stat <= i_head.status;
        end
        if (w_emit) begin
            r_out_value  <= w_emit_value;
            r_out_status <= w_emit_status;
            r_out_last   <= w_emit_last;
        end
    end

    // list memories: one write and one registered read each, read address
    // follows the next index so the data matches the index register
    always_ff @(posedge i_clk) begin
        if (w_we && !r_sel) begin
            r_mem_a[w_wr_addr] <= w_wr_data;
        end
        r_qa <= r_mem_a[n_ia[ilsm_pkg::IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_we && r_sel) begin
            r_mem_b[w_wr_addr] <= w_wr_data;
        end
        r_qb <= r_mem_b[n_ib[ilsm_pkg::IDX_W-1:0]];
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_status       = r_out_status;
    assign o_last_result  = r_out_last;

endmodule
`default_nettype wire
